[hdl/nearest_neighbor_track_id_assign_macros.svh]
// Assertion helpers for the track id block. Expect clk and rst in scope.
`ifndef NEAREST_NEIGHBOR_TRACK_ID_ASSIGN_MACROS_SVH
`define NEAREST_NEIGHBOR_TRACK_ID_ASSIGN_MACROS_SVH

// Same-cycle implication.
`define NNTA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nnta assertion failed");

// Next-cycle implication.
`define NNTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nnta assertion failed");

`endif

[hdl/nnta_pkg.sv]
package nnta_pkg;

  localparam int ID_W   = 32;
  localparam int GATE_W = 16;

  localparam logic [GATE_W-1:0] GATE_RESET = 16'd512;

  // tuser codes on the input side
  localparam logic [1:0] MODE_CENT     = 2'd0;
  localparam logic [1:0] MODE_CENT_EOF = 2'd1;
  localparam logic [1:0] MODE_EOF      = 2'd2;
  localparam logic [1:0] MODE_IGNORE   = 2'd3;  // beat taken, nothing happens

  // tag that rides along the distance pipeline
  typedef struct packed {
    logic            vld;
    logic [ID_W-1:0] track;
  } dist_tag_t;

endpackage

[hdl/nnta_cell.sv]
// One slot of a stored-centroid ring: loads its neighbor's entry on shift.
module nnta_cell #(
  parameter int W = 104
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

[hdl/nnta_dist.sv]
// Squared distance, three register stages: |diff|, squares, sum.
module nnta_dist #(
  parameter int C = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  nnta_pkg::dist_tag_t      tag_in,
  input  logic signed [C-1:0]      qx,
  input  logic signed [C-1:0]      qy,
  input  logic signed [C-1:0]      qz,
  input  logic signed [C-1:0]      ex,
  input  logic signed [C-1:0]      ey,
  input  logic signed [C-1:0]      ez,
  output nnta_pkg::dist_tag_t      tag_out,
  output logic [2*C+3:0]           dsum
);

  // difference of two C-bit signed values fits C+1 bits (C+2 kept here); magnitude fits C+1
  logic signed [C+1:0] dx, dy, dz;
  logic [C:0]          mx, my, mz;
  logic [2*C+1:0]      sx, sy, sz;
  nnta_pkg::dist_tag_t tag1, tag2;

  always_comb begin
    dx = (C+2)'(qx) - (C+2)'(ex);
    dy = (C+2)'(qy) - (C+2)'(ey);
    dz = (C+2)'(qz) - (C+2)'(ez);
  end

  always_ff @(posedge clk) begin
    mx   <= dx[C+1] ? (C+1)'(-dx) : (C+1)'(dx);
    my   <= dy[C+1] ? (C+1)'(-dy) : (C+1)'(dy);
    mz   <= dz[C+1] ? (C+1)'(-dz) : (C+1)'(dz);
    sx   <= mx * mx;
    sy   <= my * my;
    sz   <= mz * mz;
    dsum <= (2*C+4)'(sx) + (2*C+4)'(sy) + (2*C+4)'(sz);
    tag1.track    <= tag_in.track;
    tag2.track    <= tag1.track;
    tag_out.track <= tag2.track;
    if (rst) begin
      tag1.vld    <= 1'b0;
      tag2.vld    <= 1'b0;
      tag_out.vld <= 1'b0;
    end else begin
      tag1.vld    <= tag_in.vld;
      tag2.vld    <= tag1.vld;
      tag_out.vld <= tag2.vld;
    end
  end

endmodule

[hdl/nearest_neighbor_track_id_assign.sv]
// Gated nearest-neighbor track id assignment. Centroids (x, y, z, signed, 8 fraction
// bits) arrive as beats on s_*, tuser giving the kind: centroid, centroid closing the
// frame, or bare end of frame. Each centroid is checked against every centroid of the
// previous frame; it takes the id of the strictly nearest one whose squared distance is
// below gate_distance squared (earliest stored wins ties), otherwise a fresh id from a
// counter running 1..2^32-1 and wrapping to 1. The result beat on m_* carries the id,
// a matched flag and a dropped flag (current frame already held MAX_CLUSTERS entries).
// Flow: a centroid is accepted, the whole previous-frame ring rotates once past the
// distance pipeline, and the result is registered once the output is free; no new beat
// is taken before that. A bare end-of-frame beat only closes the frame. A finished result
// sits in the output register while the next beat is taken. The user must write
// gate_distance on cfg_* only while the block is idle; the block does not enforce it.
module nearest_neighbor_track_id_assign #(
  parameter int MAX_CLUSTERS = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // pos_x, pos_y, pos_z, zero pad
  input  logic [1:0]                            s_tuser,  // mode
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [nnta_pkg::ID_W-1:0]             m_tdata,  // track_id
  output logic [1:0]                            m_tuser,  // matched, dropped
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nnta_pkg::GATE_W-1:0]           cfg_data  // gate_distance
);

`include "nearest_neighbor_track_id_assign_macros.svh"

  localparam int C    = COORD_BITS;
  localparam int IDW  = nnta_pkg::ID_W;
  localparam int EW   = 3*C + IDW;               // ring entry: {track, z, y, x}
  localparam int CNTW = $clog2(MAX_CLUSTERS+1);
  localparam int SCW  = $clog2(MAX_CLUSTERS+3);
  localparam int DW   = 2*C + 4;
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_CLUSTERS);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t               state;
  logic [SCW-1:0]       cnt;
  logic                 bank_select;             // ring holding the current frame
  logic [CNTW-1:0]      prev_count, cur_count;
  logic [IDW-1:0]       next_track;
  logic [nnta_pkg::GATE_W-1:0] gate;
  logic [2*nnta_pkg::GATE_W-1:0] gate_sq;
  logic                 eof_pending;
  logic signed [C-1:0]  qx, qy, qz;
  logic                 found;
  logic [DW-1:0]        best_d;
  logic [IDW-1:0]       best_track;

  logic                 issue, out_free, store, emit;
  logic [1:0]           shift_en;
  logic [EW-1:0]        ring_q [2][MAX_CLUSTERS];
  logic [EW-1:0]        ring_d [2][MAX_CLUSTERS];
  logic [EW-1:0]        head, new_entry;
  nnta_pkg::dist_tag_t  tag_in, tag_out;
  logic [DW-1:0]        dsum;
  logic                 hit;
  logic [IDW-1:0]       res_id;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == ST_DONE) && out_free;

  // Previous ring rotates once per scan; current ring shifts a new entry in at slot 0.
  assign issue     = (state == ST_SCAN) && (cnt < SCW'(MAX_CLUSTERS));
  assign store     = (state == ST_DONE) && out_free && (cur_count < CNTW'(MAX_CLUSTERS));
  assign res_id    = found ? best_track : next_track;
  assign new_entry = {res_id, qz, qy, qx};
  assign head      = bank_select ? ring_q[0][MAX_CLUSTERS-1] : ring_q[1][MAX_CLUSTERS-1];

  always_comb begin
    shift_en[0] = bank_select ? issue : store;
    shift_en[1] = bank_select ? store : issue;
  end

  for (genvar b = 0; b < 2; b++) begin : g_ring
    for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_slot
      if (i == 0) begin : g_first
        assign ring_d[b][i] = (bank_select == 1'(b)) ? new_entry
                                                     : ring_q[b][MAX_CLUSTERS-1];
      end else begin : g_rest
        assign ring_d[b][i] = ring_q[b][i-1];
      end
      nnta_cell #(.W(EW)) u_cell (
        .clk (clk),
        .en  (shift_en[b]),
        .d   (ring_d[b][i]),
        .q   (ring_q[b][i])
      );
    end
  end

  // Entry j of a frame with P entries sits in slot P-1-j, so at scan step t the head
  // shows entry t-(MAX-P): entries come out in store order, valid once t >= MAX-P.
  always_comb begin
    tag_in.vld   = issue &&
                   (({1'b0, cnt} + (SCW+1)'(prev_count)) >= (SCW+1)'(MAX_CLUSTERS));
    tag_in.track = head[EW-1 -: IDW];
  end

  nnta_dist #(.C(C)) u_dist (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_in),
    .qx      (qx),
    .qy      (qy),
    .qz      (qz),
    .ex      (head[C-1:0]),
    .ey      (head[2*C-1:C]),
    .ez      (head[3*C-1:2*C]),
    .tag_out (tag_out),
    .dsum    (dsum)
  );

  // Inside the gate and strictly nearer than the best so far.
  assign hit = tag_out.vld && (dsum < DW'(gate_sq)) && (!found || (dsum < best_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      bank_select <= 1'b0;
      prev_count  <= '0;
      cur_count   <= '0;
      next_track  <= IDW'(1);
      gate        <= nnta_pkg::GATE_RESET;
      m_tvalid    <= 1'b0;
      found       <= 1'b0;
      eof_pending <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gate <= cfg_data;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == nnta_pkg::MODE_EOF) begin
              bank_select <= !bank_select;
              prev_count  <= cur_count;
              cur_count   <= '0;
            end else if (s_tuser == nnta_pkg::MODE_CENT ||
                         s_tuser == nnta_pkg::MODE_CENT_EOF) begin
              qx          <= s_tdata[C-1:0];
              qy          <= s_tdata[2*C-1:C];
              qz          <= s_tdata[3*C-1:2*C];
              eof_pending <= (s_tuser == nnta_pkg::MODE_CENT_EOF);
              gate_sq     <= gate * gate;
              found       <= 1'b0;
              cnt         <= '0;
              state       <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cnt <= cnt + SCW'(1);
          if (hit) begin
            found      <= 1'b1;
            best_d     <= dsum;
            best_track <= tag_out.track;
          end
          // last head issued at MAX-1 lands in best as the scan ends
          if (cnt == SCW'(MAX_CLUSTERS+2)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata    <= res_id;
            m_tuser[0] <= found;
            m_tuser[1] <= !store;
            if (!found) begin
              next_track <= (next_track == '1) ? IDW'(1) : next_track + IDW'(1);
            end
            if (eof_pending) begin
              bank_select <= !bank_select;
              prev_count  <= store ? cur_count + CNTW'(1) : cur_count;
              cur_count   <= '0;
            end else if (store) begin
              cur_count <= cur_count + CNTW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `NNTA_ASSERT_IMPL(a_track_nonzero, m_tvalid, m_tdata != '0)
  `NNTA_ASSERT_IMPL(a_count_bound, 1'b1, cur_count <= CNT_MAX && prev_count <= CNT_MAX)
  `NNTA_ASSERT_NEXT(a_fresh_advance, state == ST_DONE && out_free && !found, next_track != $past(next_track) && m_tvalid)

endmodule

[tb/sv/nearest_neighbor_track_id_assign_test.sv]
module nearest_neighbor_track_id_assign_test;

  localparam int MAX_CLUSTERS = 64;
  localparam int COORD_BITS   = 24;
  localparam int SETTLE       = MAX_CLUSTERS + 16;  // quiet cycles before a gate write
  localparam int CYCLE_LIMIT  = 600000;

  // kinds of entries in the stimulus queue
  localparam logic [1:0] K_BEAT  = 2'd0;  // one s_* beat
  localparam logic [1:0] K_GATE  = 2'd1;  // gate_distance write, block idle
  localparam logic [1:0] K_DRAIN = 2'd2;  // hold off until all results are back

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [1:0]                  kind;
    logic [1:0]                  mode;
    coord_t                      x, y, z;
    logic [nnta_pkg::GATE_W-1:0] gate;
  } stim_t;

  typedef struct {
    logic [nnta_pkg::ID_W-1:0] track_id;
    logic                      matched;
    logic                      dropped;
  } assoc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata = '0;  // pos_x, pos_y, pos_z
  logic [1:0] s_tuser = nnta_pkg::MODE_CENT;        // mode
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [nnta_pkg::ID_W-1:0] m_tdata;               // track_id
  logic [1:0] m_tuser;                              // matched, dropped
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [nnta_pkg::GATE_W-1:0] cfg_data = nnta_pkg::GATE_RESET;

  nearest_neighbor_track_id_assign #(
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .COORD_BITS  (COORD_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  stim_t  pending[$];
  assoc_t assoc_q[$];
  int     errors = 0;
  int     cycles = 0;

  // Association model: two banks, bank_sel is the one being filled.
  coord_t                    bank_x[2][MAX_CLUSTERS];
  coord_t                    bank_y[2][MAX_CLUSTERS];
  coord_t                    bank_z[2][MAX_CLUSTERS];
  logic [nnta_pkg::ID_W-1:0] bank_id[2][MAX_CLUSTERS];
  logic                      bank_sel = 1'b0;
  int                        prev_cnt = 0;
  int                        cur_cnt  = 0;
  logic [nnta_pkg::ID_W-1:0] fresh_id = 1;
  logic [nnta_pkg::GATE_W-1:0] gate_r = nnta_pkg::GATE_RESET;

  function automatic logic [63:0] sq_dist(coord_t ax, coord_t ay, coord_t az,
                                          coord_t bx, coord_t by, coord_t bz);
    longint dx, dy, dz;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
  endfunction

  task automatic close_frame();
    bank_sel = ~bank_sel;
    prev_cnt = cur_cnt;
    cur_cnt  = 0;
  endtask

  task automatic associate(logic [1:0] mode, coord_t x, coord_t y, coord_t z);
    logic [63:0] best, d;
    assoc_t      r;
    int          pb;
    if (mode == nnta_pkg::MODE_IGNORE) return;
    if (mode == nnta_pkg::MODE_EOF) begin
      close_frame();
      return;
    end
    best = 64'(gate_r) * 64'(gate_r);
    r = '{track_id: '0, matched: 1'b0, dropped: 1'b0};
    pb = bank_sel ? 0 : 1;
    for (int j = 0; j < prev_cnt; j++) begin
      d = sq_dist(x, y, z, bank_x[pb][j], bank_y[pb][j], bank_z[pb][j]);
      if (d < best) begin  // strict: earliest entry keeps a tie
        best = d;
        r.track_id = bank_id[pb][j];
        r.matched = 1'b1;
      end
    end
    if (!r.matched) begin
      r.track_id = fresh_id;
      fresh_id = (fresh_id == '1) ? nnta_pkg::ID_W'(1) : fresh_id + nnta_pkg::ID_W'(1);
    end
    if (cur_cnt >= MAX_CLUSTERS) begin
      r.dropped = 1'b1;
    end else begin
      bank_x[bank_sel][cur_cnt] = x;
      bank_y[bank_sel][cur_cnt] = y;
      bank_z[bank_sel][cur_cnt] = z;
      bank_id[bank_sel][cur_cnt] = r.track_id;
      cur_cnt++;
    end
    assoc_q.insert(assoc_q.size(), r);
    if (mode == nnta_pkg::MODE_CENT_EOF) close_frame();
  endtask

  // Driver: one entry per beat, random gap before each, gap-free stretches.
  int   src_gap = 0;
  int   quiet = 0;
  logic src_burst = 1'b0;
  always @(posedge clk) begin
    stim_t it;
    logic  busy;
    logic  send_beat;
    logic  send_cfg;
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) associate(s_tuser, s_tdata[23:0], s_tdata[47:24],
                                          s_tdata[71:48]);
      if (cfg_valid && cfg_ready) gate_r = cfg_data;
      busy = (s_tvalid && !s_tready) || (cfg_valid && !cfg_ready);
      quiet = (assoc_q.size() == 0 && !s_tvalid && !cfg_valid) ? quiet + 1 : 0;
      send_beat = 1'b0;
      send_cfg = 1'b0;
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending.size() > 0) begin
          it = pending[0];
          case (it.kind)
            K_BEAT: begin
              send_beat = 1'b1;
              s_tuser <= it.mode;
              s_tdata <= {it.z, it.y, it.x};
              void'(pending.pop_front());
            end
            K_GATE: begin
              if (quiet >= SETTLE) begin
                send_cfg = 1'b1;
                cfg_data <= it.gate;
                void'(pending.pop_front());
              end
            end
            default: begin
              if (quiet >= 2) void'(pending.pop_front());
            end
          endcase
          if ($urandom_range(0, 31) == 0) src_burst = ~src_burst;
          src_gap = src_burst ? 0 : $urandom_range(0, 8);
        end
        s_tvalid <= send_beat;
        cfg_valid <= send_cfg;
      end
    end
  end

  // Monitor: random stall per result, compare against oldest prediction.
  int   sink_stall = 0;
  logic sink_burst = 1'b0;
  always @(posedge clk) begin
    assoc_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (assoc_q.size() == 0) begin
          $error("result beat with nothing expected: track_id %0d", m_tdata);
          errors++;
        end else begin
          e = assoc_q.pop_front();
          if (m_tdata !== e.track_id) begin
            $error("track_id expected %0d actual %0d", e.track_id, m_tdata);
            errors++;
          end
          if (m_tuser[0] !== e.matched) begin
            $error("matched expected %0b actual %0b", e.matched, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.dropped) begin
            $error("dropped expected %0b actual %0b", e.dropped, m_tuser[1]);
            errors++;
          end
        end
        if ($urandom_range(0, 31) == 0) sink_burst = ~sink_burst;
        sink_stall = sink_burst ? 0 : $urandom_range(0, 8);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end
      m_tready <= (sink_stall == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_beat(logic [1:0] mode, coord_t x, coord_t y, coord_t z);
    stim_t s;
    s = '{kind: K_BEAT, mode: mode, x: x, y: y, z: z, gate: '0};
    pending.insert(pending.size(), s);
  endtask

  task automatic add_gate(logic [nnta_pkg::GATE_W-1:0] g);
    stim_t s;
    s = '{kind: K_GATE, mode: nnta_pkg::MODE_CENT, x: '0, y: '0, z: '0, gate: g};
    pending.insert(pending.size(), s);
  endtask

  task automatic add_drain();
    stim_t s;
    s = '{kind: K_DRAIN, mode: nnta_pkg::MODE_CENT, x: '0, y: '0, z: '0, gate: '0};
    pending.insert(pending.size(), s);
  endtask

  function automatic coord_t jitter(coord_t base, int span);
    return coord_t'(longint'(base) + $urandom_range(0, 2 * span) - span);
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom);
  endfunction

  coord_t tx[8], ty[8], tz[8];

  initial begin
    int n, k, items;
    logic [1:0] md;
    // directed: extremes, boundary of the gate, tie, ignored kind, empty frame
    add_gate(nnta_pkg::GATE_RESET);
    add_beat(nnta_pkg::MODE_CENT, 24'sd0, 24'sd0, 24'sd0);
    add_beat(nnta_pkg::MODE_CENT, 24'sd1000, 24'sd0, 24'sd0);
    add_beat(nnta_pkg::MODE_CENT, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd8388607, 24'sd8388607, 24'sd8388607);
    add_beat(nnta_pkg::MODE_CENT, 24'sd500, 24'sd0, 24'sd0);  // tie: earliest wins
    add_beat(nnta_pkg::MODE_CENT, 24'sd0, 24'sd511, 24'sd0);  // just inside
    add_beat(nnta_pkg::MODE_CENT, 24'sd0, 24'sd0, 24'sd512);  // on the gate: fresh id
    add_beat(nnta_pkg::MODE_CENT, 24'sd8388607, 24'sd8388607, 24'sd8388606);
    add_beat(nnta_pkg::MODE_CENT, -24'sd8388608, 24'sd8388607, 24'sd0);
    add_beat(nnta_pkg::MODE_IGNORE, 24'sd5, 24'sd5, 24'sd5);
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd1000, 24'sd0, 24'sd0);
    add_beat(nnta_pkg::MODE_CENT, 24'sd1, 24'sd1, 24'sd1);
    add_beat(nnta_pkg::MODE_EOF, 24'sd0, 24'sd0, 24'sd0);
    add_beat(nnta_pkg::MODE_EOF, 24'sd0, 24'sd0, 24'sd0);  // empty frame: no previous set
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd1, 24'sd1, 24'sd1);
    add_drain();
    add_gate(16'd0);                      // nothing can match
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd1, 24'sd1, 24'sd1);
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd1, 24'sd1, 24'sd1);
    add_gate(16'hFFFF);
    add_beat(nnta_pkg::MODE_CENT_EOF, -24'sd8388608, 24'sd0, 24'sd0);
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd8388607, 24'sd0, 24'sd0);
    add_beat(nnta_pkg::MODE_CENT_EOF, 24'sd8388607, 24'sd16000, 24'sd16000);
    add_gate(nnta_pkg::GATE_RESET);
    // overfull frame: entries past the bank depth are dropped
    for (int i = 0; i < MAX_CLUSTERS + 4; i++)
      add_beat(i == MAX_CLUSTERS + 3 ? nnta_pkg::MODE_CENT_EOF : nnta_pkg::MODE_CENT,
               coord_t'(i * 2000), 24'sd0, 24'sd0);
    for (int i = 0; i < MAX_CLUSTERS + 2; i++)
      add_beat(nnta_pkg::MODE_CENT, coord_t'(i * 2000 + 7), 24'sd3, -24'sd3);
    add_beat(nnta_pkg::MODE_EOF, 24'sd0, 24'sd0, 24'sd0);

    // random frames of moving clusters, with noise and gate changes
    for (int t = 0; t < 8; t++) begin
      tx[t] = rnd_coord(); ty[t] = rnd_coord(); tz[t] = rnd_coord();
    end
    items = 0;
    while (items < 740) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 4))
          0: add_gate(16'd0);
          1: add_gate(16'hFFFF);
          2: add_gate(16'd1);
          default: add_gate(16'($urandom_range(64, 2048)));
        endcase
      end
      if ($urandom_range(0, 29) == 0) add_drain();
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        k = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) begin
          md = 2'($urandom_range(0, 3));
          add_beat(md == nnta_pkg::MODE_EOF ? nnta_pkg::MODE_CENT : md,
                   rnd_coord(), rnd_coord(), rnd_coord());
        end else begin
          tx[k] = jitter(tx[k], 200); ty[k] = jitter(ty[k], 200); tz[k] = jitter(tz[k], 60);
          add_beat((i == n - 1 && $urandom_range(0, 1)) ? nnta_pkg::MODE_CENT_EOF
                                                         : nnta_pkg::MODE_CENT,
                   jitter(tx[k], 300), jitter(ty[k], 300), jitter(tz[k], 100));
        end
        items++;
      end
      if (n == 0 || $urandom_range(0, 1)) begin
        add_beat(nnta_pkg::MODE_EOF, rnd_coord(), rnd_coord(), rnd_coord());
        items++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() > 0 || s_tvalid || cfg_valid || assoc_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (assoc_q.size() > 0) begin
      $error("%0d results never arrived", assoc_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/nnta_pkg.sv
hdl/nnta_cell.sv
hdl/nnta_dist.sv
hdl/nearest_neighbor_track_id_assign.sv
tb/sv/nearest_neighbor_track_id_assign_test.sv
